[sv/lddfg_pkg.sv]
package lddfg_pkg;

  // controller register addresses
  localparam logic [3:0] ADDR_SHUTDOWN    = 4'hC;
  localparam logic [3:0] ADDR_SCAN_LIMIT  = 4'hB;
  localparam logic [3:0] ADDR_INTENSITY   = 4'hA;
  localparam logic [3:0] ADDR_DECODE_MODE = 4'h9;

  // configuration register indexes
  localparam logic [2:0] CFG_SHUTDOWN    = 3'd0;
  localparam logic [2:0] CFG_SCAN_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_INTENSITY   = 3'd2;
  localparam logic [2:0] CFG_DECODE_MODE = 3'd3;

  // input command codes
  localparam logic CMD_SHOW = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // header frame order during initialization
  localparam logic [1:0] HDR_SHUTDOWN    = 2'd0;
  localparam logic [1:0] HDR_SCAN_LIMIT  = 2'd1;
  localparam logic [1:0] HDR_INTENSITY   = 2'd2;
  localparam logic [1:0] HDR_DECODE_MODE = 2'd3;

  localparam int MAX_FRAMES  = 10;
  localparam int HDR_FRAMES  = 4;

  // reciprocal of ten for 16-bit operands: q = (x * 0xCCCD) >> 19
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0] shutdown_value;
    logic [2:0] scan_limit;
    logic [3:0] intensity;
    logic [7:0] decode_mode;
  } cfg_t;

  // classified command word passed from front to back
  typedef struct packed {
    logic        is_init;
    logic        group;
    logic [15:0] number;
  } desc_t;

endpackage

[sv/lddfg_front.sv]
module lddfg_front (
  input  logic                 start,
  input  logic                 in_command,
  input  logic                 in_display_select,
  input  logic [15:0]          in_number,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output lddfg_pkg::desc_t     desc
);

  // accept a word whenever the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // classify: initialization clears the digits, so it carries number zero
  always_comb begin
    desc.is_init = (in_command == lddfg_pkg::CMD_INIT);
    desc.group   = in_display_select;
    desc.number  = (in_command == lddfg_pkg::CMD_INIT) ? 16'd0 : in_number;
  end

endmodule

[sv/lddfg_queue.sv]
module lddfg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lddfg_pkg::desc_t  push_desc,
  input  logic              pop,
  output logic              q_valid,
  output logic              q_full,
  output lddfg_pkg::desc_t  q_desc
);

  lddfg_pkg::desc_t entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_desc  = entry_r[rd_ptr_r];

  // hold pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // store the incoming word
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

endmodule

[sv/lddfg_back.sv]
module lddfg_back #(
  parameter int DIGITS_PER_DISPLAY = 3,
  parameter int NUM_DISPLAYS       = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lddfg_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  lddfg_pkg::desc_t  q_desc,
  output logic              pop,
  output logic              out_valid,
  output logic [3:0]        out_register_address,
  output logic [7:0]        out_register_data,
  output logic              out_last_frame
);

  localparam int DW = (DIGITS_PER_DISPLAY > 1) ? $clog2(DIGITS_PER_DISPLAY) : 1;
  localparam int INIT_ALL = lddfg_pkg::HDR_FRAMES + DIGITS_PER_DISPLAY * NUM_DISPLAYS;
  localparam int TOTAL_INIT = (INIT_ALL > lddfg_pkg::MAX_FRAMES) ?
                              lddfg_pkg::MAX_FRAMES : INIT_ALL;
  localparam int TOTAL_SHOW = DIGITS_PER_DISPLAY;
  localparam logic [3:0] LAST_INIT = 4'(TOTAL_INIT - 1);
  localparam logic [3:0] LAST_SHOW = 4'(TOTAL_SHOW - 1);
  localparam logic [DW-1:0] DIG_LAST = DW'(DIGITS_PER_DISPLAY - 1);
  localparam logic [3:0] DIG_STRIDE = 4'(DIGITS_PER_DISPLAY);

  logic          active_r;
  logic          init_r;
  logic          hdr_r;
  logic [1:0]    hdr_idx_r;
  logic [DW-1:0] dig_r;
  logic          disp_r;
  logic          grp_r;
  logic [15:0]   rest_r;
  logic [3:0]    cnt_r;

  logic [31:0]   prod;
  logic [15:0]   quot;
  logic [15:0]   rem_full;
  logic [3:0]    frame_addr;
  logic [7:0]    frame_data;
  logic          frame_last;
  logic          cur_grp;

  // split off the lowest decimal digit
  assign prod     = rest_r * lddfg_pkg::RECIP_TEN;
  assign quot     = 16'(prod[31:lddfg_pkg::RECIP_SHIFT]);
  assign rem_full = rest_r - ((quot << 3) + (quot << 1));

  assign cur_grp    = init_r ? disp_r : grp_r;
  assign frame_last = (cnt_r == (init_r ? LAST_INIT : LAST_SHOW));
  assign pop        = q_valid && (!active_r || frame_last);

  // build the current frame
  always_comb begin
    frame_addr = 4'(dig_r) + (cur_grp ? DIG_STRIDE : 4'd0) + 4'd1;
    frame_data = {4'd0, rem_full[3:0]};
    if (hdr_r) begin
      case (hdr_idx_r)
        lddfg_pkg::HDR_SHUTDOWN: begin
          frame_addr = lddfg_pkg::ADDR_SHUTDOWN;
          frame_data = cfg.shutdown_value;
        end
        lddfg_pkg::HDR_SCAN_LIMIT: begin
          frame_addr = lddfg_pkg::ADDR_SCAN_LIMIT;
          frame_data = {5'd0, cfg.scan_limit};
        end
        lddfg_pkg::HDR_INTENSITY: begin
          frame_addr = lddfg_pkg::ADDR_INTENSITY;
          frame_data = {4'd0, cfg.intensity};
        end
        lddfg_pkg::HDR_DECODE_MODE: begin
          frame_addr = lddfg_pkg::ADDR_DECODE_MODE;
          frame_data = cfg.decode_mode;
        end
        default: begin
          frame_addr = lddfg_pkg::ADDR_SHUTDOWN;
          frame_data = cfg.shutdown_value;
        end
      endcase
    end
  end

  // sequence frames, load the next word on the last frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (pop) begin
      active_r <= 1'b1;
    end else if (active_r && frame_last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      init_r    <= q_desc.is_init;
      hdr_r     <= q_desc.is_init;
      hdr_idx_r <= lddfg_pkg::HDR_SHUTDOWN;
      dig_r     <= '0;
      disp_r    <= 1'b0;
      grp_r     <= q_desc.group;
      rest_r    <= q_desc.number;
      cnt_r     <= 4'd0;
    end else if (active_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (hdr_r) begin
        hdr_idx_r <= hdr_idx_r + 2'd1;
        if (hdr_idx_r == lddfg_pkg::HDR_DECODE_MODE) hdr_r <= 1'b0;
      end else begin
        rest_r <= quot;
        if (dig_r == DIG_LAST) begin
          dig_r  <= '0;
          disp_r <= ~disp_r;
        end else begin
          dig_r <= dig_r + DW'(1);
        end
      end
    end
  end

  // register the frame onto the result ports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_register_address <= frame_addr;
    out_register_data    <= frame_data;
    out_last_frame       <= frame_last;
  end

endmodule

[sv/led_digit_display_frame_gen.sv]
// Register-write frame generator for an 8-digit LED display controller.
// Input channel: a command word is taken at a clock edge where start is
// high and busy is low. Command show splits in_number into its lowest
// DIGITS_PER_DISPLAY decimal digits and writes them to the digit group
// chosen by in_display_select; command init writes shutdown, scan limit,
// intensity and decode mode from the configuration registers and then
// zeroes every digit (ten frames at default parameters).
// Result channel: out_valid marks one frame for one cycle; out_last_frame
// flags the final frame of a command. The receiver cannot stall.
// Throughput: one frame per cycle from the frame sequencer; a show
// writes DIGITS_PER_DISPLAY frames and an init up to ten; a two-word queue
// lets commands arrive while a burst is still going, and busy is high
// only while that queue is full. Bursts follow each other without gaps.
// Configuration: cfg_we writes cfg_wdata to register cfg_index; write
// only while idle. Reset empties the queue, stops any burst and returns
// the registers to 1, 7, 15 and 255.
module led_digit_display_frame_gen #(
  parameter int DIGITS_PER_DISPLAY = 3,
  parameter int NUM_DISPLAYS       = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic        in_display_select,
  input  logic [15:0] in_number,
  output logic        out_valid,
  output logic [3:0]  out_register_address,
  output logic [7:0]  out_register_data,
  output logic        out_last_frame,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  lddfg_pkg::cfg_t  cfg_r;
  lddfg_pkg::desc_t push_desc;
  lddfg_pkg::desc_t q_desc;
  logic             push, pop, q_valid, q_full;

  // hold configuration registers, keep only their low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown_value <= 8'd1;
      cfg_r.scan_limit     <= 3'd7;
      cfg_r.intensity      <= 4'd15;
      cfg_r.decode_mode    <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        lddfg_pkg::CFG_SHUTDOWN:    cfg_r.shutdown_value <= cfg_wdata;
        lddfg_pkg::CFG_SCAN_LIMIT:  cfg_r.scan_limit     <= cfg_wdata[2:0];
        lddfg_pkg::CFG_INTENSITY:   cfg_r.intensity      <= cfg_wdata[3:0];
        lddfg_pkg::CFG_DECODE_MODE: cfg_r.decode_mode    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lddfg_front u_front (
    .start             (start),
    .in_command        (in_command),
    .in_display_select (in_display_select),
    .in_number         (in_number),
    .q_full            (q_full),
    .busy              (busy),
    .push              (push),
    .desc              (push_desc)
  );

  lddfg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_desc    (q_desc)
  );

  lddfg_back #(
    .DIGITS_PER_DISPLAY (DIGITS_PER_DISPLAY),
    .NUM_DISPLAYS       (NUM_DISPLAYS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_desc               (q_desc),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_register_address (out_register_address),
    .out_register_data    (out_register_data),
    .out_last_frame       (out_last_frame)
  );

endmodule

[dv/lddfg_frame_checker.sv]
`timescale 1ns / 100ps
module lddfg_frame_checker #(
  parameter int DIGITS_PER_DISPLAY = 3,
  parameter int NUM_DISPLAYS       = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_command,
  input  logic        in_display_select,
  input  logic [15:0] in_number,
  input  logic        out_valid,
  input  logic [3:0]  out_register_address,
  input  logic [7:0]  out_register_data,
  input  logic        out_last_frame,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          frames_due,
  output int          fail_count
);

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } frame_t;

  lddfg_pkg::cfg_t regs;
  frame_t burst_q[$];
  frame_t frames_q[$];
  frame_t want;
  int     fails = 0;

  initial begin
    frames_due = 0;
    fail_count = 0;
  end

  // add one frame to the burst under construction, capped at the burst limit
  function automatic void add_frame(input logic [3:0] a, input logic [7:0] d);
    frame_t f;
    f.addr = a;
    f.data = d;
    f.last = 1'b0;
    if (burst_q.size() < lddfg_pkg::MAX_FRAMES) burst_q.push_back(f);
  endfunction

  // split a number into its lowest decimal digits, least significant first
  function automatic void add_digits(input int grp, input logic [15:0] num);
    logic [15:0] rest;
    int          full_addr;
    logic [3:0]  a;
    rest = num;
    for (int i = 0; i < DIGITS_PER_DISPLAY; i++) begin
      full_addr = i + DIGITS_PER_DISPLAY * grp + 1;
      a = full_addr[3:0];
      add_frame(a, 8'(rest % 16'd10));
      rest = rest / 16'd10;
    end
  endfunction

  // build the frames of one command word and queue them, final one flagged
  function automatic void expand_word(input logic cmd, input logic grp,
                                      input logic [15:0] num);
    frame_t f;
    burst_q.delete();
    if (cmd == lddfg_pkg::CMD_INIT) begin
      add_frame(lddfg_pkg::ADDR_SHUTDOWN, regs.shutdown_value);
      add_frame(lddfg_pkg::ADDR_SCAN_LIMIT, {5'd0, regs.scan_limit});
      add_frame(lddfg_pkg::ADDR_INTENSITY, {4'd0, regs.intensity});
      add_frame(lddfg_pkg::ADDR_DECODE_MODE, regs.decode_mode);
      for (int g = 0; g < NUM_DISPLAYS; g++) add_digits(g, 16'd0);
    end else begin
      add_digits(int'(grp), num);
    end
    for (int k = 0; k < burst_q.size(); k++) begin
      f = burst_q[k];
      f.last = (k == burst_q.size() - 1);
      frames_q.push_back(f);
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val,
                                      input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{shutdown_value: 8'd1, scan_limit: 3'd7, intensity: 4'd15,
               decode_mode: 8'd255};
      frames_q.delete();
    end else begin
      // track register writes, dropping bits above each register's width
      if (cfg_we) begin
        case (cfg_index)
          lddfg_pkg::CFG_SHUTDOWN:    regs.shutdown_value = cfg_wdata;
          lddfg_pkg::CFG_SCAN_LIMIT:  regs.scan_limit = cfg_wdata[2:0];
          lddfg_pkg::CFG_INTENSITY:   regs.intensity = cfg_wdata[3:0];
          lddfg_pkg::CFG_DECODE_MODE: regs.decode_mode = cfg_wdata;
          default: ;
        endcase
      end
      // predict the burst of each accepted word
      if (start && !busy) expand_word(in_command, in_display_select, in_number);
      // compare each frame with the oldest prediction
      if (out_valid) begin
        if (frames_q.size() == 0) begin
          $display("%0t: unexpected frame, expected none, actual addr 0x%0h data 0x%0h last %0b",
                   $time, out_register_address, out_register_data, out_last_frame);
          fails++;
        end else begin
          want = frames_q.pop_front();
          check_field("register_address", want.addr, out_register_address);
          check_field("register_data", want.data, out_register_data);
          check_field("last_frame", want.last, out_last_frame);
        end
      end
    end
    frames_due <= frames_q.size();
    fail_count <= fails;
  end

endmodule

[dv/led_digit_display_frame_gen_test.sv]
`timescale 1ns / 100ps
module led_digit_display_frame_gen_test;

  localparam int DIGITS      = 3;
  localparam int DISPLAYS    = 2;
  localparam int STALL_LIMIT = 1000;
  localparam int IDLE_PCT    = 18;

  // indexes past the register list; writes there must be ignored
  localparam logic [2:0] CFG_SPARE_FIRST = 3'd4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_command = lddfg_pkg::CMD_SHOW;
  logic        in_display_select = 1'b0;
  logic [15:0] in_number = 16'd0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = lddfg_pkg::CFG_SHUTDOWN;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        busy;
  logic        out_valid;
  logic [3:0]  out_register_address;
  logic [7:0]  out_register_data;
  logic        out_last_frame;
  int          frames_due;
  int          fail_count;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;

  led_digit_display_frame_gen #(
    .DIGITS_PER_DISPLAY(DIGITS),
    .NUM_DISPLAYS(DISPLAYS)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_display_select(in_display_select),
    .in_number(in_number),
    .out_valid(out_valid), .out_register_address(out_register_address),
    .out_register_data(out_register_data), .out_last_frame(out_last_frame),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  lddfg_frame_checker #(
    .DIGITS_PER_DISPLAY(DIGITS),
    .NUM_DISPLAYS(DISPLAYS)
  ) frame_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_display_select(in_display_select),
    .in_number(in_number),
    .out_valid(out_valid), .out_register_address(out_register_address),
    .out_register_data(out_register_data), .out_last_frame(out_last_frame),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .frames_due(frames_due), .fail_count(fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // present one command word, hold it until taken, then maybe idle
  task automatic send_word(input logic cmd, input logic sel, input logic [15:0] num);
    in_command <= cmd;
    in_display_select <= sel;
    in_number <= num;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drop start and wait until every predicted frame has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // load all four registers, then poke a spare index with junk
  task automatic load_regs(input logic [7:0] sd, input logic [7:0] sl,
                           input logic [7:0] inten, input logic [7:0] dm);
    write_reg(lddfg_pkg::CFG_SHUTDOWN, sd);
    write_reg(lddfg_pkg::CFG_SCAN_LIMIT, sl);
    write_reg(lddfg_pkg::CFG_INTENSITY, inten);
    write_reg(lddfg_pkg::CFG_DECODE_MODE, dm);
    write_reg(CFG_SPARE_FIRST + 3'($urandom_range(3)), 8'($urandom_range(255)));
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    logic        cmd;
    logic [15:0] num;
    cmd = ($urandom_range(99) < 20) ? lddfg_pkg::CMD_INIT : lddfg_pkg::CMD_SHOW;
    case ($urandom_range(3))
      0: num = 16'($urandom_range(999));
      1: num = 16'(65535 - $urandom_range(50));
      default: num = 16'($urandom_range(65535));
    endcase
    send_word(cmd, 1'($urandom_range(1)), num);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, digit extremes and carries on both groups
    send_word(lddfg_pkg::CMD_INIT, 1'b0, 16'd0);
    send_word(lddfg_pkg::CMD_SHOW, 1'b0, 16'd0);
    send_word(lddfg_pkg::CMD_SHOW, 1'b1, 16'd65535);
    send_word(lddfg_pkg::CMD_SHOW, 1'b0, 16'd999);
    send_word(lddfg_pkg::CMD_SHOW, 1'b1, 16'd1000);
    send_word(lddfg_pkg::CMD_SHOW, 1'b0, 16'd12345);
    send_word(lddfg_pkg::CMD_SHOW, 1'b1, 16'h5555);
    send_word(lddfg_pkg::CMD_SHOW, 1'b0, 16'hAAAA);
    send_word(lddfg_pkg::CMD_SHOW, 1'b1, 16'd7);
    send_word(lddfg_pkg::CMD_INIT, 1'b1, 16'hFFFF);

    // all registers at zero
    wait_drained();
    load_regs(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(lddfg_pkg::CMD_INIT, 1'b0, 16'd0);
    send_word(lddfg_pkg::CMD_SHOW, 1'b1, 16'd1);

    // all registers at max, written with oversized values
    wait_drained();
    load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(lddfg_pkg::CMD_INIT, 1'b1, 16'd0);
    send_word(lddfg_pkg::CMD_SHOW, 1'b0, 16'd100);

    // random settings; one phase runs with no idling
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      idle_on = (p != 2);
      repeat (24) random_word();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && frames_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // count cycles with work outstanding but nothing moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (!start && frames_due == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

[files.f]
sv/lddfg_pkg.sv
sv/lddfg_front.sv
sv/lddfg_queue.sv
sv/lddfg_back.sv
sv/led_digit_display_frame_gen.sv
dv/lddfg_frame_checker.sv
dv/led_digit_display_frame_gen_test.sv
